/* rtl/bole_pkg.sv */
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

   localparam int KEY_W        = 32;
   localparam int COUNT_OUT_W  = 5;
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [2:0] {
      OP_INS_FRONT  = 3'd0,
      OP_INS_BACK   = 3'd1,
      OP_INS_SORTED = 3'd2,
      OP_RM_FIRST   = 3'd3,
      OP_RM_LAST    = 3'd4,
      OP_RM_KEY     = 3'd5,
      OP_CONTAINS   = 3'd6,
      OP_CLEAR      = 3'd7
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [KEY_W-1:0]   key_value;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic signed [KEY_W-1:0]      removed_value;
      logic [COUNT_OUT_W-1:0]       entry_count;
      logic                         is_empty;
   } rsp_type;

   // Broadcast from the top level to every cell in the row.
   typedef struct packed {
      op_type                    operation;
      logic signed [KEY_W-1:0]   key_value;
      logic                      ins_en;
      logic                      rem_en;
   } cell_ctl_type;

endpackage

/* rtl/bounded_ordered_list_engine.sv */
// Latency: a result strobes on the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while busy is low; the found flag ripples
// combinationally through the cell row, so the row length sets the critical path.
// Reset: synchronous, clears the entry count; busy is high during reset and
// in the cycle after it. The receiver cannot stall, so results never wait.
module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic                    busy_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   logic                    accept;
   logic                    full;
   logic                    is_ins;
   logic                    is_rem;
   cell_ctl_type            ctl;

   logic                    found_chain [0:CAPACITY];
   logic signed [KEY_W-1:0] value_chain [0:CAPACITY];
   logic signed [KEY_W-1:0] entry_row   [0:CAPACITY-1];

   assign busy   = reset || busy_ff;
   assign accept = start && !busy;
   assign full   = (cnt_ff == CNT_FULL);

   assign is_ins = (req_data.operation == OP_INS_FRONT) ||
                   (req_data.operation == OP_INS_BACK)  ||
                   (req_data.operation == OP_INS_SORTED);
   assign is_rem = (req_data.operation == OP_RM_FIRST) ||
                   (req_data.operation == OP_RM_LAST)  ||
                   (req_data.operation == OP_RM_KEY);

   assign ctl.operation = req_data.operation;
   assign ctl.key_value = req_data.key_value;
   assign ctl.ins_en    = accept && is_ins && !full;
   assign ctl.rem_en    = accept && is_rem;

   assign found_chain[0] = 1'b0;
   assign value_chain[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_entry;
      logic signed [KEY_W-1:0] right_entry;

      if (i == 0) begin : g_head
         assign left_entry = req_data.key_value;
      end else begin : g_body
         assign left_entry = entry_row[i-1];
      end

      if (i == CAPACITY-1) begin : g_tail
         assign right_entry = entry_row[i];
      end else begin : g_inner
         assign right_entry = entry_row[i+1];
      end

      bole_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (cnt_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .found_in    (found_chain[i]),
         .value_in    (value_chain[i]),
         .found_out   (found_chain[i+1]),
         .value_out   (value_chain[i+1]),
         .entry_out   (entry_row[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      rsp_in = '0;
      case (req_data.operation)
         OP_INS_FRONT,
         OP_INS_BACK,
         OP_INS_SORTED: begin
            rsp_in.ok = !full;
            if (!full) begin
               cnt_in = cnt_ff + CNT_ONE;
            end
         end
         OP_RM_FIRST,
         OP_RM_LAST,
         OP_RM_KEY: begin
            rsp_in.ok = found_chain[CAPACITY];
            if (found_chain[CAPACITY]) begin
               cnt_in               = cnt_ff - CNT_ONE;
               rsp_in.removed_value = value_chain[CAPACITY];
            end
         end
         OP_CONTAINS: begin
            rsp_in.ok = found_chain[CAPACITY];
         end
         default: begin
            rsp_in.ok = 1'b1;
            cnt_in    = '0;
         end
      endcase
      rsp_in.entry_count = COUNT_OUT_W'(cnt_in);
      rsp_in.is_empty    = (cnt_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= accept;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/bole_cell.sv */
// One storage cell of the list row: holds one key and shifts with its neighbors.
module bole_cell
   import bole_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int INDEX    = 0
) (
   input  logic                                clock,
   input  cell_ctl_type                        ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]       count,
   input  logic signed [KEY_W-1:0]             left_entry,
   input  logic signed [KEY_W-1:0]             right_entry,
   input  logic                                found_in,
   input  logic signed [KEY_W-1:0]             value_in,
   output logic                                found_out,
   output logic signed [KEY_W-1:0]             value_out,
   output logic signed [KEY_W-1:0]             entry_out
);

   localparam int CNT_W = $clog2(CAPACITY+1);
   localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] NEXT_POS = CNT_W'(INDEX + 1);
   localparam logic IS_HEAD = (INDEX == 0);

   logic signed [KEY_W-1:0] entry_ff;
   logic signed [KEY_W-1:0] entry_in;
   logic                    valid;
   logic                    hit;
   logic                    first_hit;

   assign valid = MY_POS < count;

   always_comb begin
      case (ctl.operation)
         OP_INS_FRONT:  hit = IS_HEAD;
         OP_INS_BACK:   hit = (count == MY_POS);
         OP_INS_SORTED: hit = (valid && !(entry_ff < ctl.key_value)) || (count == MY_POS);
         OP_RM_FIRST:   hit = IS_HEAD && valid;
         OP_RM_LAST:    hit = (count == NEXT_POS);
         OP_RM_KEY,
         OP_CONTAINS:   hit = valid && (entry_ff == ctl.key_value);
         default:       hit = 1'b0;
      endcase
   end

   // The found flag and the value of the first matching cell ripple toward the tail.
   assign first_hit = hit && !found_in;
   assign found_out = found_in || hit;
   assign value_out = first_hit ? entry_ff : value_in;
   assign entry_out = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_en) begin
         if (found_in) begin
            entry_in = left_entry;
         end else if (hit) begin
            entry_in = ctl.key_value;
         end
      end else if (ctl.rem_en && found_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/bole_checker.sv */
// Port-level checks for the bounded ordered list engine, bound to the top level.
module bole_checker
   import bole_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     busy,
   input  req_type  req_data,
   input  logic     rsp_strobe,
   input  rsp_type  rsp_data
);

   // Every accepted transaction yields exactly one result on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted transaction produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result strobe without an accepted transaction");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == OP_CLEAR) |=>
         (rsp_data.ok && rsp_data.is_empty))
      else $error("clear did not leave the list empty");

   a_no_removed_value: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == OP_INS_FRONT ||
                          req_data.operation == OP_INS_BACK ||
                          req_data.operation == OP_INS_SORTED ||
                          req_data.operation == OP_CONTAINS ||
                          req_data.operation == OP_CLEAR)) |=>
         (rsp_data.removed_value == '0))
      else $error("removed value reported for a non-remove transaction");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_empty) |-> (rsp_data.entry_count == '0))
      else $error("empty flag set with a nonzero entry count");

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);
